[sv/life_grid_engine_assert.svh]
// assertion helpers for the cell grid engine
`ifndef LIFE_GRID_ENGINE_ASSERT_SVH
`define LIFE_GRID_ENGINE_ASSERT_SVH

// same-cycle implication
`define LGE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LGE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/lge_pkg.sv]
`default_nettype none

package lge_pkg;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_STEP  = 2'd2,
    CMD_PLACE = 2'd3
  } cmd_e;

  localparam logic [1:0] PAT_RPENT   = 2'd0;
  localparam logic [1:0] PAT_DIEHARD = 2'd1;
  localparam logic [1:0] PAT_ACORN   = 2'd2;

  localparam logic CFG_GRID_ROWS = 1'b0;
  localparam logic CFG_GRID_COLS = 1'b1;

  localparam int unsigned DIM_W = 7;
  localparam logic [DIM_W-1:0] GRID_DIM_RESET = 7'd64;
  localparam logic [DIM_W-1:0] GRID_DIM_MIN   = 7'd3;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CELL_RD,
    S_CELL_OP,
    S_PAT_CHK,
    S_PAT_WR,
    S_STEP_RD0,
    S_STEP_RD1,
    S_STEP_RD2,
    S_STEP_WAIT,
    S_STEP_CELL,
    S_STEP_WB,
    S_RESP
  } state_e;

  typedef struct packed {
    logic signed [1:0] dr;
    logic signed [3:0] dc;
  } offset_t;

  // padded to eight, entries past the pattern length are never used
  localparam offset_t RPENT_TBL [8] = '{
    '{dr: 2'sd0,  dc: -4'sd1}, '{dr: 2'sd0,  dc: 4'sd0}, '{dr: 2'sd1, dc: 4'sd0},
    '{dr: -2'sd1, dc: 4'sd0},  '{dr: -2'sd1, dc: 4'sd1}, '{dr: 2'sd0, dc: 4'sd0},
    '{dr: 2'sd0,  dc: 4'sd0},  '{dr: 2'sd0,  dc: 4'sd0}
  };

  localparam offset_t DIEHARD_TBL [8] = '{
    '{dr: 2'sd0,  dc: -4'sd3}, '{dr: 2'sd0, dc: -4'sd2}, '{dr: 2'sd1, dc: -4'sd2},
    '{dr: -2'sd1, dc: 4'sd3},  '{dr: 2'sd1, dc: 4'sd3},  '{dr: 2'sd1, dc: 4'sd2},
    '{dr: 2'sd1,  dc: 4'sd4},  '{dr: 2'sd0, dc: 4'sd0}
  };

  localparam offset_t ACORN_TBL [8] = '{
    '{dr: -2'sd1, dc: -4'sd2}, '{dr: 2'sd1, dc: -4'sd3}, '{dr: 2'sd1, dc: -4'sd2},
    '{dr: 2'sd0,  dc: 4'sd0},  '{dr: 2'sd1, dc: 4'sd1},  '{dr: 2'sd1, dc: 4'sd2},
    '{dr: 2'sd1,  dc: 4'sd3},  '{dr: 2'sd0, dc: 4'sd0}
  };

  function automatic logic [3:0] pat_len(logic [1:0] pat);
    logic [3:0] n;
    case (pat)
      PAT_RPENT:   n = 4'd5;
      PAT_DIEHARD: n = 4'd7;
      PAT_ACORN:   n = 4'd7;
      default:     n = 4'd0;
    endcase
    return n;
  endfunction

  function automatic offset_t pat_offset(logic [1:0] pat, logic [2:0] k);
    offset_t o;
    case (pat)
      PAT_RPENT:   o = RPENT_TBL[k];
      PAT_DIEHARD: o = DIEHARD_TBL[k];
      PAT_ACORN:   o = ACORN_TBL[k];
      default:     o = '0;
    endcase
    return o;
  endfunction

endpackage

`default_nettype wire

[sv/life_grid_engine.sv]
// cell grid engine, B3/S23 rules, command driven
// request channel: in_valid_i / in_stall_o carries cmd_i, row_i, col_i,
//   cell_value_i and pattern_i; a request is taken when valid is high and
//   stall is low. the engine stalls from acceptance until its response leaves.
// response channel: out_valid_o / out_stall_i carries read_value_o and
//   status_o, one response per request, held while out_stall_i is high; the
//   next request is taken the cycle after the response is taken.
// configuration: cfg_we_i writes cfg_wdata_i to grid_rows (index 0) or
//   grid_cols (index 1); write only while no request is in flight.
// operation: write and read fetch the cell's row from the row memory, then update or
//   return the cell; a cell outside the grid skips the access and gets error status.
//   a pattern sets each of its cells inside the grid and flags any it skips. a step is
//   paced by the single neighbor-count unit, which handles one cell per cycle within a
//   row, over a three-row window read from the row memory one row at a time.
// reset: the grid memory is cleared one row per cycle, with requests stalled;
//   configuration writes are taken meanwhile.
`default_nettype none

`include "life_grid_engine_assert.svh"

module life_grid_engine
  import lge_pkg::*;
#(
  parameter int unsigned MAX_ROWS = 64,
  parameter int unsigned MAX_COLS = 64
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic             cfg_idx_i,
  input  wire logic [DIM_W-1:0] cfg_wdata_i,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [1:0]       cmd_i,
  input  wire logic [5:0]       row_i,
  input  wire logic [5:0]       col_i,
  input  wire logic             cell_value_i,
  input  wire logic [1:0]       pattern_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic                  read_value_o,
  output logic                  status_o
);

  localparam int unsigned RAW = $clog2(MAX_ROWS);
  localparam int unsigned CAW = $clog2(MAX_COLS);
  localparam logic [DIM_W-1:0] ROWS_CAP = (MAX_ROWS > 127) ? 7'd127 : DIM_W'(MAX_ROWS);
  localparam logic [DIM_W-1:0] COLS_CAP = (MAX_COLS > 127) ? 7'd127 : DIM_W'(MAX_COLS);
  localparam logic [RAW-1:0] LAST_ROW = RAW'(MAX_ROWS - 1);

  function automatic logic [RAW-1:0] row_addr(logic [7:0] v);
    logic [15:0] w;
    w = 16'(v);
    return w[RAW-1:0];
  endfunction

  function automatic logic [CAW-1:0] col_idx(logic [7:0] v);
    logic [15:0] w;
    w = 16'(v);
    return w[CAW-1:0];
  endfunction

  function automatic logic in_grid(logic signed [7:0] r, logic signed [7:0] c,
                                   logic [DIM_W-1:0] rows, logic [DIM_W-1:0] cols);
    return (r >= 0) && (r < signed'({1'b0, rows})) &&
           (c >= 0) && (c < signed'({1'b0, cols}));
  endfunction

  // control state
  state_e           state_q, state_d;
  logic [DIM_W-1:0] grid_rows_q, grid_cols_q;
  logic [RAW-1:0]   clr_q, clr_d;
  logic [DIM_W-1:0] r_q, r_d;
  logic [DIM_W-1:0] c_q, c_d;
  logic [2:0]       k_q, k_d;

  // request and response payload
  logic [1:0] cmd_q;
  logic [5:0] row_q, col_q;
  logic       val_q;
  logic [1:0] pat_q;
  logic       rd_q, rd_d;
  logic       st_q, st_d;

  // step window
  logic [MAX_COLS-1:0] above_q, above_d;
  logic [MAX_COLS-1:0] mid_q, mid_d;
  logic [MAX_COLS-1:0] below_q, below_d;
  logic [MAX_COLS-1:0] newrow_q, newrow_d;

  // row memory
  logic [MAX_COLS-1:0] mem_q [MAX_ROWS];
  logic [MAX_COLS-1:0] mem_rdata_q;
  logic                mem_we;
  logic [RAW-1:0]      mem_wa, mem_ra;
  logic [MAX_COLS-1:0] mem_wd;

  logic [DIM_W-1:0] rows_eff, cols_eff;
  logic             accept;
  logic             cell_in;
  offset_t          pofs;
  logic signed [7:0] pr, pc;
  logic             p_in;
  logic [CAW-1:0]   cm1, c0, cp1;
  logic [3:0]       ncount;
  logic             alive;

  always_comb begin
    if (grid_rows_q < GRID_DIM_MIN) begin
      rows_eff = GRID_DIM_MIN;
    end else if (grid_rows_q > ROWS_CAP) begin
      rows_eff = ROWS_CAP;
    end else begin
      rows_eff = grid_rows_q;
    end
    if (grid_cols_q < GRID_DIM_MIN) begin
      cols_eff = GRID_DIM_MIN;
    end else if (grid_cols_q > COLS_CAP) begin
      cols_eff = COLS_CAP;
    end else begin
      cols_eff = grid_cols_q;
    end
  end

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = (state_q == S_RESP);
  assign read_value_o = rd_q;
  assign status_o     = st_q;
  assign accept       = in_valid_i && !in_stall_o;

  assign cell_in = ({1'b0, row_q} < rows_eff) && ({1'b0, col_q} < cols_eff);

  // pattern cell coordinates
  assign pofs = pat_offset(pat_q, k_q);
  assign pr   = signed'({2'b00, row_q}) + 8'(pofs.dr);
  assign pc   = signed'({2'b00, col_q}) + 8'(pofs.dc);
  assign p_in = in_grid(pr, pc, rows_eff, cols_eff);

  // neighbor count unit
  assign cm1 = col_idx(8'(c_q) - 8'd1);
  assign c0  = col_idx(8'(c_q));
  assign cp1 = col_idx(8'(c_q) + 8'd1);
  assign ncount = 4'(above_q[cm1]) + 4'(above_q[c0]) + 4'(above_q[cp1]) +
                  4'(mid_q[cm1]) + 4'(mid_q[cp1]) +
                  4'(below_q[cm1]) + 4'(below_q[c0]) + 4'(below_q[cp1]);
  assign alive = (ncount == 4'd3) || (mid_q[c0] && (ncount == 4'd2));

  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    r_d      = r_q;
    c_d      = c_q;
    k_d      = k_q;
    rd_d     = rd_q;
    st_d     = st_q;
    above_d  = above_q;
    mid_d    = mid_q;
    below_d  = below_q;
    newrow_d = newrow_q;
    mem_we   = 1'b0;
    mem_wa   = '0;
    mem_wd   = '0;
    mem_ra   = '0;
    unique case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_q;
        clr_d  = clr_q + RAW'(1);
        if (clr_q == LAST_ROW) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          rd_d = 1'b0;
          st_d = 1'b0;
          k_d  = '0;
          unique case (cmd_e'(cmd_i)) inside
            CMD_WRITE, CMD_READ: state_d = S_CELL_RD;
            CMD_STEP:            state_d = S_STEP_RD0;
            CMD_PLACE:           state_d = S_PAT_CHK;
          endcase
        end
      end
      S_CELL_RD: begin
        mem_ra = row_addr({2'b00, row_q});
        if (cell_in) begin
          state_d = S_CELL_OP;
        end else begin
          st_d    = 1'b1;
          state_d = S_RESP;
        end
      end
      S_CELL_OP: begin
        if (cmd_q == CMD_READ) begin
          rd_d = mem_rdata_q[col_idx({2'b00, col_q})];
        end else begin
          mem_we = 1'b1;
          mem_wa = row_addr({2'b00, row_q});
          mem_wd = mem_rdata_q;
          mem_wd[col_idx({2'b00, col_q})] = val_q;
        end
        state_d = S_RESP;
      end
      S_PAT_CHK: begin
        mem_ra = row_addr(pr);
        if ({1'b0, k_q} == pat_len(pat_q)) begin
          state_d = S_RESP;
        end else if (p_in) begin
          state_d = S_PAT_WR;
        end else begin
          st_d = 1'b1;
          k_d  = k_q + 3'd1;
        end
      end
      S_PAT_WR: begin
        mem_we = 1'b1;
        mem_wa = row_addr(pr);
        mem_wd = mem_rdata_q;
        mem_wd[col_idx(pc)] = 1'b1;
        k_d     = k_q + 3'd1;
        state_d = S_PAT_CHK;
      end
      S_STEP_RD0: begin
        mem_ra  = row_addr(8'd0);
        state_d = S_STEP_RD1;
      end
      S_STEP_RD1: begin
        mem_ra  = row_addr(8'd1);
        above_d = mem_rdata_q;
        state_d = S_STEP_RD2;
      end
      S_STEP_RD2: begin
        mem_ra   = row_addr(8'd2);
        mid_d    = mem_rdata_q;
        newrow_d = mem_rdata_q;
        r_d      = 7'd1;
        state_d  = S_STEP_WAIT;
      end
      S_STEP_WAIT: begin
        below_d = mem_rdata_q;
        c_d     = 7'd1;
        state_d = S_STEP_CELL;
      end
      S_STEP_CELL: begin
        newrow_d[c0] = alive;
        c_d = c_q + 7'd1;
        if (c_q == cols_eff - 7'd2) begin
          state_d = S_STEP_WB;
        end
      end
      S_STEP_WB: begin
        mem_we   = 1'b1;
        mem_wa   = row_addr(8'(r_q));
        mem_wd   = newrow_q;
        above_d  = mid_q;
        mid_d    = below_q;
        newrow_d = below_q;
        if (r_q == rows_eff - 7'd2) begin
          state_d = S_RESP;
        end else begin
          mem_ra  = row_addr(8'(r_q) + 8'd2);
          r_d     = r_q + 7'd1;
          state_d = S_STEP_WAIT;
        end
      end
      S_RESP: begin
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      r_q         <= '0;
      c_q         <= '0;
      k_q         <= '0;
      grid_rows_q <= GRID_DIM_RESET;
      grid_cols_q <= GRID_DIM_RESET;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      r_q     <= r_d;
      c_q     <= c_d;
      k_q     <= k_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_GRID_ROWS: grid_rows_q <= cfg_wdata_i;
          CFG_GRID_COLS: grid_cols_q <= cfg_wdata_i;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_i;
      row_q <= row_i;
      col_q <= col_i;
      val_q <= cell_value_i;
      pat_q <= pattern_i;
    end
    rd_q     <= rd_d;
    st_q     <= st_d;
    above_q  <= above_d;
    mid_q    <= mid_d;
    below_q  <= below_d;
    newrow_q <= newrow_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    mem_rdata_q <= mem_q[mem_ra];
  end

  `LGE_ASSERT_IMP(a_no_accept_with_response, !in_stall_o, !out_valid_o, "request taken while a response is pending")
  `LGE_ASSERT_NXT(a_busy_after_accept, accept, in_stall_o, "engine not busy after taking a request")
  `LGE_ASSERT_IMP(a_read_only_when_ok, out_valid_o && read_value_o, !status_o, "live read reported with error status")
  `LGE_ASSERT_IMP(a_step_never_flags, out_valid_o && (cmd_q == CMD_STEP), !status_o && !read_value_o, "step response not clean")

endmodule

`default_nettype wire
